[rtl/rrts_pkg.sv]
// Shared constants, types and event codes of the round-robin time-slice scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int RING_DEPTH    = 64;
  localparam int DURATION_BITS = 16;

  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int TAG_W   = 8;
  localparam int DUR_W   = DURATION_BITS;
  localparam int QUANT_W = 10;
  localparam int TIME_W  = 32;

  // Port field widths.
  localparam int DUR_PORT_W = 16;
  localparam int KIND_W     = 3;
  localparam int QCNT_W     = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 10'd10;
  localparam logic [QUANT_W-1:0] SLICE_MAX     = {QUANT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    EV_ACCEPTED  = 3'd0,
    EV_REJECTED  = 3'd1,
    EV_IDLE      = 3'd2,
    EV_RAN       = 3'd3,
    EV_COMPLETED = 3'd4,
    EV_ROTATED   = 3'd5
  } event_kind_t;

  typedef enum logic {
    REQ_ARRIVAL = 1'b0,
    REQ_TICK    = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [DUR_W-1:0] duration;
    logic [DUR_W-1:0] remaining;
  } ring_entry_t;

endpackage

[rtl/round_robin_time_slice_scheduler_unit.sv]
// Top level of the round-robin time-slice scheduler: ring memory, control and result register.
`timescale 1ns / 1ps

// Round-robin scheduler with a configurable quantum. An arrival beat (in_tuser = 0) appends a job
// to the ready ring; a tick beat (in_tuser = 1) gives one time unit to the front job, retires
// it when done or moves it to the back after a full quantum, and advances the time counter.
// Every input beat yields exactly one output beat. An item passes through the accept cycle,
// in which the front entry of the ring memory is read, and then the execute state, in which
// the registered read data is updated and written back. The ready ring is a single-port-write
// memory with a registered read. The block takes a new item while a finished result still
// waits in the output register; it stays in the execute state only while that register is
// full and not being drained. No clearing pass is needed after reset, since a ring entry is
// only read after it has been written.
module round_robin_time_slice_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: quantum.
  input  logic                            cfg_wr_en,
  input  logic [rrts_pkg::QUANT_W-1:0]    cfg_wr_data,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rrts_pkg::IN_DATA_W-1:0]  in_tdata,   // job_tag[7:0], job_duration[23:8]
  input  logic                            in_tuser,   // req_type
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rrts_pkg::OUT_DATA_W-1:0] out_tdata,  // out_tag[7:0], out_duration[23:8],
                                                      // consumed[24], time_now[56:25],
                                                      // queue_count[63:57]
  output logic [rrts_pkg::KIND_W-1:0]     out_tuser   // event_kind
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                          st_r, st_nxt;
  logic [rrts_pkg::QUANT_W-1:0]    quantum_r;
  logic [rrts_pkg::IDX_W-1:0]      head_r, head_nxt;
  logic [rrts_pkg::IDX_W-1:0]      tail_r, tail_nxt;
  logic [rrts_pkg::CNT_W-1:0]      occ_r, occ_nxt;
  logic [rrts_pkg::QUANT_W-1:0]    slice_r, slice_nxt;
  logic [rrts_pkg::TIME_W-1:0]     time_r, time_nxt;

  // Latched input item.
  logic                            req_r;
  logic [rrts_pkg::TAG_W-1:0]      tag_r;
  logic [rrts_pkg::DUR_W-1:0]      dur_r;

  // Ring memory.
  rrts_pkg::ring_entry_t           ring_mem [rrts_pkg::RING_DEPTH];
  rrts_pkg::ring_entry_t           rd_q_r;
  logic                            wr_en;
  logic [rrts_pkg::IDX_W-1:0]      wr_addr;
  rrts_pkg::ring_entry_t           wr_data;

  // Output register.
  logic                            out_tvalid_r;
  logic [rrts_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [rrts_pkg::KIND_W-1:0]     out_tuser_r;

  // Result of the item in flight.
  rrts_pkg::event_kind_t           res_kind;
  logic [rrts_pkg::TAG_W-1:0]      res_tag;
  logic [rrts_pkg::DUR_W-1:0]      res_dur;
  logic                            res_used;

  logic                            in_acc;
  logic                            out_free;
  logic                            commit;
  logic                            ring_full;
  logic                            ring_empty;
  logic                            give;
  logic [rrts_pkg::DUR_W-1:0]      rem_new;
  logic [rrts_pkg::QUANT_W-1:0]    slice_inc;
  logic [rrts_pkg::IDX_W-1:0]      head_inc;
  logic [rrts_pkg::IDX_W-1:0]      tail_inc;

  assign in_tready  = (st_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign commit     = (st_r == S_EXEC) && out_free;
  assign ring_full  = (occ_r == rrts_pkg::CNT_W'(rrts_pkg::RING_DEPTH));
  assign ring_empty = (occ_r == '0);

  assign head_inc = (head_r == rrts_pkg::IDX_W'(rrts_pkg::RING_DEPTH - 1)) ? '0
                                                                          : head_r + 1'b1;
  assign tail_inc = (tail_r == rrts_pkg::IDX_W'(rrts_pkg::RING_DEPTH - 1)) ? '0
                                                                          : tail_r + 1'b1;

  // Front job update for a tick.
  assign give      = (rd_q_r.duration != '0) && (rd_q_r.remaining != '0);
  assign rem_new   = give ? rd_q_r.remaining - 1'b1 : rd_q_r.remaining;
  assign slice_inc = (give && (slice_r != rrts_pkg::SLICE_MAX)) ? slice_r + 1'b1 : slice_r;

  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    slice_nxt = slice_r;
    time_nxt  = time_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    wr_data   = '{tag: tag_r, duration: dur_r, remaining: dur_r};
    res_kind  = rrts_pkg::EV_ACCEPTED;
    res_tag   = tag_r;
    res_dur   = dur_r;
    res_used  = 1'b0;

    if (req_r == rrts_pkg::REQ_ARRIVAL) begin
      if (ring_full) begin
        res_kind = rrts_pkg::EV_REJECTED;
      end else begin
        wr_en    = 1'b1;
        tail_nxt = tail_inc;
        occ_nxt  = occ_r + 1'b1;
      end
    end else begin
      time_nxt = time_r + 1'b1;
      if (ring_empty) begin
        res_kind = rrts_pkg::EV_IDLE;
        res_tag  = '0;
        res_dur  = '0;
      end else begin
        res_tag  = rd_q_r.tag;
        res_dur  = rd_q_r.duration;
        res_used = give;
        wr_data  = '{tag: rd_q_r.tag, duration: rd_q_r.duration, remaining: rem_new};
        if (rem_new == '0) begin
          res_kind  = rrts_pkg::EV_COMPLETED;
          head_nxt  = head_inc;
          occ_nxt   = occ_r - 1'b1;
          slice_nxt = '0;
        end else if (slice_inc >= quantum_r) begin
          // The updated entry moves to the tail slot; in a full ring that is the head slot.
          res_kind  = rrts_pkg::EV_ROTATED;
          wr_en     = 1'b1;
          wr_addr   = tail_r;
          head_nxt  = head_inc;
          tail_nxt  = tail_inc;
          slice_nxt = '0;
        end else begin
          res_kind  = rrts_pkg::EV_RAN;
          wr_en     = 1'b1;
          wr_addr   = head_r;
          slice_nxt = slice_inc;
        end
      end
    end

    if (!commit) begin
      wr_en = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // The head entry is read every cycle; no write lands during the cycle that uses it.
  always_ff @(posedge clk) begin
    rd_q_r <= ring_mem[head_r];
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      quantum_r <= rrts_pkg::QUANTUM_RESET;
      head_r    <= '0;
      tail_r    <= '0;
      occ_r     <= '0;
      slice_r   <= '0;
      time_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      if (commit) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        occ_r   <= occ_nxt;
        slice_r <= slice_nxt;
        time_r  <= time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_tuser;
      tag_r <= in_tdata[rrts_pkg::TAG_W-1:0];
      dur_r <= rrts_pkg::DUR_W'(in_tdata[rrts_pkg::TAG_W +: rrts_pkg::DUR_PORT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_tuser_r <= res_kind;
      out_tdata_r <= {rrts_pkg::QCNT_W'(occ_nxt), time_r, res_used,
                      rrts_pkg::DUR_PORT_W'(res_dur), res_tag};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
